/* rtl/lfx_pkg.sv */
// Package for the lagged Fibonacci XOR generator: wheel geometry, lags, codes.
package lfx_pkg;

	localparam int WHEEL_DEPTH = 256;
	localparam int ADDR_W      = $clog2(WHEEL_DEPTH);
	localparam int WORD_W      = 32;
	localparam int SEED_IDX_W  = 8;
	localparam int RANGE_W     = 16;

	localparam int LAG_A = 11;
	localparam int LAG_B = 29;
	localparam int LAG_X = 17;

	// forward offsets that step an index back by each lag
	localparam int OFF_A = WHEEL_DEPTH - (LAG_A % WHEEL_DEPTH);
	localparam int OFF_B = WHEEL_DEPTH - (LAG_B % WHEEL_DEPTH);
	localparam int OFF_X = WHEEL_DEPTH - (LAG_X % WHEEL_DEPTH);

	localparam int NUM_TAPS = 3;
	localparam int TAP_A    = 0;
	localparam int TAP_B    = 1;
	localparam int TAP_X    = 2;

	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	localparam logic REG_RANGE_LOW  = 1'b0;
	localparam logic REG_RANGE_HIGH = 1'b1;

	localparam logic signed [RANGE_W-1:0] RANGE_LOW_RST  = -16'sd4096;
	localparam logic signed [RANGE_W-1:0] RANGE_HIGH_RST = 16'sd4096;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [WORD_W-1:0] word_t;

	function automatic addr_t wheel_back(input addr_t p, input int off);
		logic [ADDR_W:0] t;
		t = {1'b0, p} + (ADDR_W+1)'(off);
		if (t >= (ADDR_W+1)'(WHEEL_DEPTH)) begin
			t = t - (ADDR_W+1)'(WHEEL_DEPTH);
		end
		return t[ADDR_W-1:0];
	endfunction

endpackage

/* rtl/lfx_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
module lfx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/lagged_fibonacci_xor_generator.sv */
// Lagged Fibonacci XOR generator top level: wheel RAMs, pipeline, APB registers.
// Throughput: one item per cycle unless m_tready stalls; the three wheel
// lags are read from three RAM copies (one read port each) and the last
// write is bypassed.
// Reset: position 0, range_low -4096, range_high 4096, pipeline empty;
// the wheel RAM contents are not cleared and must be loaded before drawing.
module lagged_fibonacci_xor_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [7:0] seed_index, [39:8] seed_word
	input  logic        s_tuser,  // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [31:0] random_word, [47:32] scaled_value
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lfx_pkg::*;

	// config registers
	logic signed [RANGE_W-1:0] range_low_q, range_high_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= RANGE_LOW_RST;
			range_high_q <= RANGE_HIGH_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_RANGE_LOW:  range_low_q  <= pwdata[RANGE_W-1:0];
				REG_RANGE_HIGH: range_high_q <= pwdata[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RANGE_LOW:  prdata = 32'(range_low_q);
			REG_RANGE_HIGH: prdata = 32'(range_high_q);
			default:        prdata = '0;
		endcase
	end

	// handshake chain
	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	logic in_fire;

	assign rdy_s3   = !v_s3 || m_tready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign in_fire  = s_tvalid && s_tready;

	// position and read addresses
	addr_t pos_q;
	addr_t ra_next [NUM_TAPS];

	assign ra_next[TAP_A] = wheel_back(pos_q, OFF_A);
	assign ra_next[TAP_B] = wheel_back(pos_q, OFF_B);
	assign ra_next[TAP_X] = wheel_back(pos_q, OFF_X);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_fire) begin
			unique case (s_tuser)
				OP_LOAD: pos_q <= '0;
				OP_DRAW: pos_q <= (pos_q == ADDR_W'(WHEEL_DEPTH-1)) ? '0 : pos_q + 1'b1;
				default: pos_q <= '0;
			endcase
		end
	end

	// stage 1: item plus RAM read
	logic                  op_s1;
	logic [SEED_IDX_W-1:0] idx_s1;
	word_t                 seed_s1;
	addr_t                 p_s1;
	addr_t                 ra_s1 [NUM_TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1   <= s_tuser;
			idx_s1  <= s_tdata[SEED_IDX_W-1:0];
			seed_s1 <= s_tdata[SEED_IDX_W +: WORD_W];
			p_s1    <= pos_q;
			ra_s1   <= ra_next;
		end
	end

	// wheel copies, one per lag, all written alike
	logic  wr_fire, wr_en, idx_ok_s1;
	addr_t wr_addr;
	word_t wr_data;
	word_t rd [NUM_TAPS];

	for (genvar k = 0; k < NUM_TAPS; k++) begin : g_wheel
		lfx_ram #(
			.WIDTH(WORD_W),
			.DEPTH(WHEEL_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (wr_en),
			.waddr(wr_addr),
			.wdata(wr_data),
			.re   (rdy_s1),
			.raddr(ra_next[k]),
			.rdata(rd[k])
		);
	end

	// last write, covers the write that lands on the read edge
	logic  byp_v_q;
	addr_t byp_addr_q;
	word_t byp_data_q;
	word_t opnd [NUM_TAPS];
	word_t sum_s1, word_s1;

	always_comb begin
		for (int k = 0; k < NUM_TAPS; k++) begin
			opnd[k] = (byp_v_q && byp_addr_q == ra_s1[k]) ? byp_data_q : rd[k];
		end
	end

	assign sum_s1    = opnd[TAP_A] + opnd[TAP_B];
	assign word_s1   = sum_s1 ^ opnd[TAP_X];
	assign idx_ok_s1 = {1'b0, idx_s1} < (SEED_IDX_W+1)'(WHEEL_DEPTH);
	assign wr_fire   = v_s1 && rdy_s2;
	assign wr_en     = wr_fire && (op_s1 == OP_DRAW || idx_ok_s1);
	assign wr_addr   = (op_s1 == OP_DRAW) ? p_s1 : idx_s1[ADDR_W-1:0];
	assign wr_data   = (op_s1 == OP_DRAW) ? sum_s1 : seed_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_v_q <= 1'b0;
		end else if (wr_en) begin
			byp_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			byp_addr_q <= wr_addr;
			byp_data_q <= wr_data;
		end
	end

	// stage 2: raw word, draws only
	word_t word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1 && (op_s1 == OP_DRAW);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			word_s2 <= word_s1;
		end
	end

	// stage 3: scale into range, output register
	logic signed [RANGE_W:0]          diff;
	logic signed [RANGE_W+WORD_W:0]   prod;
	logic signed [RANGE_W:0]          scaled_sum;
	word_t                            word_s3;
	logic signed [RANGE_W-1:0]        scaled_s3;

	assign diff       = $signed({range_high_q[RANGE_W-1], range_high_q})
	                  - $signed({range_low_q[RANGE_W-1], range_low_q});
	assign prod       = diff * $signed({1'b0, word_s2});
	assign scaled_sum = $signed({range_low_q[RANGE_W-1], range_low_q})
	                  + prod[WORD_W +: RANGE_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			word_s3   <= word_s2;
			scaled_s3 <= scaled_sum[RANGE_W-1:0];
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {scaled_s3, word_s3};

`ifndef SYNTH
	a_load_resets_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_tuser == OP_LOAD) |=> (pos_q == '0))
		else $error("position not cleared by load");

	a_write_on_leave: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (v_s1 && rdy_s2))
		else $error("wheel write without stage 1 item leaving");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !rdy_s3) |=> (v_s2 && $stable(word_s2)))
		else $error("stage 2 word lost during stall");
`endif

endmodule
